// ===== src/ttce_pkg.sv =====
// package for the text terminal character engine: sizes, codes and state type
package ttce_pkg;

  localparam int unsigned STORED_ROWS  = 64;
  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned VISIBLE_ROWS = 25;
  localparam int unsigned STORE_CELLS  = STORED_ROWS * COLUMNS;

  localparam int unsigned POS_W  = 13;
  localparam int unsigned ROW_W  = $clog2(STORED_ROWS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ADDR_W = $clog2(STORE_CELLS);
  localparam int unsigned VIEW_W = 6;
  localparam int unsigned SCR_W  = 11;
  localparam int unsigned WIDE_W = 10;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] RESET_COLOR  = 8'd15;
  localparam logic [6:0] RESET_PROMPT = 7'd16;

  localparam logic CFG_TEXT_COLOR    = 1'b0;
  localparam logic CFG_PROMPT_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_NL_WAIT,
    ST_BS_WAIT,
    ST_BS_CHK,
    ST_BS_WR,
    ST_TAB,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_CHAR,
    ST_VIEW_GO,
    ST_VW_WAIT,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== src/ttce_store.sv =====
// cell store memory with one write port and one registered read port
module ttce_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ttce_pkg::ADDR_W-1:0] waddr,
  input  logic [15:0]                 wdata,
  input  logic [ttce_pkg::ADDR_W-1:0] raddr,
  output logic [15:0]                 rdata
);

  logic [15:0] mem [ttce_pkg::STORE_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ttce_div.sv =====
// iterative divider by the row length: one subtract per cycle
module ttce_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ttce_pkg::POS_W-1:0] dividend,
  output logic                       done,
  output logic [ttce_pkg::ROW_W-1:0] quot,
  output logic [ttce_pkg::COL_W-1:0] rem
);

  localparam logic [ttce_pkg::POS_W-1:0] COLS = ttce_pkg::POS_W'(ttce_pkg::COLUMNS);

  logic                       run;
  logic [ttce_pkg::POS_W-1:0] acc;

  assign done = run && (acc < COLS);
  assign rem  = acc[ttce_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= dividend;
      quot <= '0;
    end else if (run && !done) begin
      acc  <= acc - COLS;
      quot <= quot + 1'b1;
    end
  end

endmodule

// ===== src/text_terminal_char_engine.sv =====
// text terminal character engine: command sequencer, cursor and view logic
//
// Usage: pulse start with command, char_code and cell_index while busy is low.
// Command 0 puts a character (newline, backspace, tab or insert), 1 reads a
// cell, 2 clears the store. Exactly one result follows each command: valid is
// high for one cycle with cell_data, cursor_cell, view_top_row and
// cursor_on_screen; busy drops in the cycle after. The receiver cannot stall.
// A backspace or an insert shifts cells one at a time, reading and then
// writing each one. The row/column split runs on one subtract unit, one row
// per cycle, and cell moves go through the single cell store.
// A clear, by command or when the view runs past the store, writes every
// cell once.
// After reset the block runs the same clearing pass with busy high.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.
module text_terminal_char_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [12:0] cell_index,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        valid,
  output logic [15:0] cell_data,
  output logic [12:0] cursor_cell,
  output logic [5:0]  view_top_row,
  output logic [10:0] cursor_on_screen
);

  localparam int unsigned PW = ttce_pkg::POS_W;
  localparam int unsigned WW = ttce_pkg::WIDE_W;
  localparam logic [PW-1:0] STORE  = PW'(ttce_pkg::STORE_CELLS);
  localparam logic [PW-1:0] LAST   = PW'(ttce_pkg::STORE_CELLS - 1);
  localparam logic [PW-1:0] COLS   = PW'(ttce_pkg::COLUMNS);
  localparam logic [WW-1:0] VROWS  = WW'(ttce_pkg::VISIBLE_ROWS);
  localparam logic [WW-1:0] SROWS  = WW'(ttce_pkg::STORED_ROWS);
  localparam logic [ttce_pkg::SCR_W-1:0] LAST_ROW_BASE =
    ttce_pkg::SCR_W'((ttce_pkg::VISIBLE_ROWS - 1) * ttce_pkg::COLUMNS);

  ttce_pkg::state_t state, state_next;

  logic [PW-1:0]  cursor, line_end, k;
  logic [ttce_pkg::VIEW_W-1:0] view;
  logic [ttce_pkg::SCR_W-1:0]  scr;
  logic [7:0]     color, ch;
  logic [6:0]     prompt;
  logic           finish;
  logic [15:0]    data_r;

  logic                            mem_we;
  logic [ttce_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [15:0]                     mem_wdata, mem_rdata;

  logic                       div_start, div_done;
  logic [PW-1:0]              div_in;
  logic [ttce_pkg::ROW_W-1:0] div_q;
  logic [ttce_pkg::COL_W-1:0] div_r;

  logic [PW-1:0] k_inc, nl_pos;
  logic [WW-1:0] row_w, view_w, view_new;

  assign k_inc  = k + 1'b1;
  assign nl_pos = line_end - PW'(div_r) + COLS;
  assign row_w  = WW'(div_q);
  assign view_w = WW'(view);
  assign view_new = (row_w >= view_w + VROWS) ? (row_w + 1'b1 - VROWS) : view_w;

  ttce_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttce_pkg::ST_IDLE: begin
        if (start) begin
          unique case (command)
            ttce_pkg::CMD_PUT: begin
              if (char_code == ttce_pkg::CH_NEWLINE) begin
                state_next = ttce_pkg::ST_NL_WAIT;
              end else if (char_code == ttce_pkg::CH_BACKSPACE) begin
                state_next = ttce_pkg::ST_BS_WAIT;
              end else if (char_code == ttce_pkg::CH_TAB) begin
                state_next = ttce_pkg::ST_TAB;
              end else if (cursor < STORE && cursor < line_end) begin
                state_next = ttce_pkg::ST_INS_RD;
              end else begin
                state_next = ttce_pkg::ST_INS_CHAR;
              end
            end
            ttce_pkg::CMD_READ: begin
              state_next = (cell_index < STORE) ? ttce_pkg::ST_RD_WAIT : ttce_pkg::ST_DONE;
            end
            ttce_pkg::CMD_CLEAR: state_next = ttce_pkg::ST_CLR;
            default:             state_next = ttce_pkg::ST_DONE;
          endcase
        end
      end
      ttce_pkg::ST_CLR: begin
        if (k == LAST) begin
          state_next = finish ? ttce_pkg::ST_DONE : ttce_pkg::ST_IDLE;
        end
      end
      ttce_pkg::ST_NL_WAIT: begin
        if (div_done) begin
          state_next = ttce_pkg::ST_VIEW_GO;
        end
      end
      ttce_pkg::ST_BS_WAIT: begin
        if (div_done) begin
          state_next = (7'(div_r) > prompt) ? ttce_pkg::ST_BS_CHK : ttce_pkg::ST_VIEW_GO;
        end
      end
      ttce_pkg::ST_BS_CHK: begin
        state_next = (k < line_end) ? ttce_pkg::ST_BS_WR : ttce_pkg::ST_VIEW_GO;
      end
      ttce_pkg::ST_BS_WR: state_next = ttce_pkg::ST_BS_CHK;
      ttce_pkg::ST_TAB: begin
        if (k == PW'(3)) begin
          state_next = ttce_pkg::ST_VIEW_GO;
        end
      end
      ttce_pkg::ST_INS_RD: state_next = ttce_pkg::ST_INS_WR;
      ttce_pkg::ST_INS_WR: begin
        state_next = (k == cursor) ? ttce_pkg::ST_INS_CHAR : ttce_pkg::ST_INS_RD;
      end
      ttce_pkg::ST_INS_CHAR: state_next = ttce_pkg::ST_VIEW_GO;
      ttce_pkg::ST_VIEW_GO:  state_next = ttce_pkg::ST_VW_WAIT;
      ttce_pkg::ST_VW_WAIT: begin
        if (div_done) begin
          state_next = (view_new + VROWS > SROWS) ? ttce_pkg::ST_CLR : ttce_pkg::ST_DONE;
        end
      end
      ttce_pkg::ST_RD_WAIT: state_next = ttce_pkg::ST_DONE;
      ttce_pkg::ST_DONE:    state_next = ttce_pkg::ST_IDLE;
      default:              state_next = ttce_pkg::ST_IDLE;
    endcase
  end

  // memory, divider and handshake controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k[ttce_pkg::ADDR_W-1:0];
    mem_wdata = {color, ttce_pkg::CH_SPACE};
    mem_raddr = cell_index[ttce_pkg::ADDR_W-1:0];
    div_start = 1'b0;
    div_in    = cursor;
    busy      = (state != ttce_pkg::ST_IDLE);
    valid     = (state == ttce_pkg::ST_DONE);
    unique case (state)
      ttce_pkg::ST_IDLE: begin
        if (start && command == ttce_pkg::CMD_PUT) begin
          div_start = (char_code == ttce_pkg::CH_NEWLINE) ||
                      (char_code == ttce_pkg::CH_BACKSPACE);
          div_in    = (char_code == ttce_pkg::CH_NEWLINE) ? line_end : cursor;
        end
      end
      ttce_pkg::ST_CLR: mem_we = 1'b1;
      ttce_pkg::ST_BS_CHK: begin
        mem_raddr = k_inc[ttce_pkg::ADDR_W-1:0];
        if (k >= line_end && line_end < STORE) begin
          mem_we    = 1'b1;
          mem_waddr = line_end[ttce_pkg::ADDR_W-1:0];
        end
      end
      ttce_pkg::ST_BS_WR: begin
        mem_we    = (k < STORE);
        mem_wdata = (k_inc < STORE) ? mem_rdata : 16'd0;
      end
      ttce_pkg::ST_TAB: begin
        mem_we    = (cursor < STORE);
        mem_waddr = cursor[ttce_pkg::ADDR_W-1:0];
      end
      ttce_pkg::ST_INS_RD: mem_raddr = k[ttce_pkg::ADDR_W-1:0];
      ttce_pkg::ST_INS_WR: begin
        mem_we    = (k_inc < STORE);
        mem_waddr = k_inc[ttce_pkg::ADDR_W-1:0];
        mem_wdata = (k < STORE) ? mem_rdata : 16'd0;
      end
      ttce_pkg::ST_INS_CHAR: begin
        mem_we    = (cursor < STORE);
        mem_waddr = cursor[ttce_pkg::ADDR_W-1:0];
        mem_wdata = {color, ch};
      end
      ttce_pkg::ST_VIEW_GO: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttce_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= ttce_pkg::RESET_COLOR;
      prompt <= ttce_pkg::RESET_PROMPT;
    end else if (cfg_write) begin
      if (cfg_index == ttce_pkg::CFG_TEXT_COLOR) begin
        color <= cfg_data;
      end else begin
        prompt <= cfg_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      finish   <= 1'b0;
      cursor   <= '0;
      line_end <= '0;
      view     <= '0;
      scr      <= '0;
    end else begin
      unique case (state)
        ttce_pkg::ST_IDLE: begin
          if (start) begin
            ch     <= char_code;
            data_r <= '0;
            finish <= 1'b1;
            k      <= (command == ttce_pkg::CMD_PUT && char_code != ttce_pkg::CH_TAB) ?
                      line_end : '0;
          end
        end
        ttce_pkg::ST_CLR: begin
          k <= k_inc;
          if (k == LAST) begin
            cursor   <= '0;
            line_end <= '0;
            view     <= '0;
            scr      <= '0;
          end
        end
        ttce_pkg::ST_NL_WAIT: begin
          if (div_done) begin
            cursor   <= (nl_pos > STORE) ? STORE : nl_pos;
            line_end <= (nl_pos > STORE) ? STORE : nl_pos;
          end
        end
        ttce_pkg::ST_BS_WAIT: begin
          if (div_done && 7'(div_r) > prompt) begin
            cursor <= cursor - 1'b1;
            k      <= cursor - 1'b1;
            if (line_end != '0) begin
              line_end <= line_end - 1'b1;
            end
          end
        end
        ttce_pkg::ST_BS_WR: k <= k_inc;
        ttce_pkg::ST_TAB: begin
          k <= k_inc;
          if (cursor < STORE) cursor <= cursor + 1'b1;
          if (line_end < STORE) line_end <= line_end + 1'b1;
        end
        ttce_pkg::ST_INS_WR: begin
          if (k != cursor) k <= k - 1'b1;
        end
        ttce_pkg::ST_INS_CHAR: begin
          if (cursor < STORE) cursor <= cursor + 1'b1;
          if (line_end < STORE) line_end <= line_end + 1'b1;
        end
        ttce_pkg::ST_VW_WAIT: begin
          if (div_done) begin
            k    <= '0;
            view <= view_new[ttce_pkg::VIEW_W-1:0];
            scr  <= (row_w < VROWS) ? cursor[ttce_pkg::SCR_W-1:0] :
                    LAST_ROW_BASE + ttce_pkg::SCR_W'(div_r);
          end
        end
        ttce_pkg::ST_RD_WAIT: data_r <= mem_rdata;
        default: begin
        end
      endcase
    end
  end

  assign cell_data        = data_r;
  assign cursor_cell      = cursor;
  assign view_top_row     = view;
  assign cursor_on_screen = scr;

endmodule
